@@ rtl/ara_pkg.sv @@
`default_nettype none
package ara_pkg;

    localparam int SLOT_BITS = 10;
    localparam int ATL_BITS  = 6;
    localparam int POS_BITS  = 14;
    localparam int GAP_RESET = 4;

    localparam logic [1:0] STATUS_OPEN    = 2'd0;
    localparam logic [1:0] STATUS_NEW     = 2'd1;
    localparam logic [1:0] STATUS_RELEASE = 2'd2;
    localparam logic [1:0] STATUS_REFUSE  = 2'd3;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [11:0] req_width;
        logic [11:0] req_height;
        logic [5:0]  release_slot;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  atlas_index;
        logic [10:0] place_x;
        logic [10:0] place_y;
        logic [5:0]  slot;
    } t_out;

    // write or clear one table entry
    typedef struct packed {
        logic                 wr;
        logic                 clr;
        logic [SLOT_BITS-1:0] slot;
        logic [ATL_BITS-1:0]  atlas;
        logic [10:0]          left;
        logic [10:0]          top;
        logic [11:0]          wide;
        logic [11:0]          tall;
    } t_cmd;

    // candidate travelling down the cell chain
    typedef struct packed {
        logic                 active;
        logic                 chk;
        logic [ATL_BITS-1:0]  atlas;
        logic [POS_BITS-1:0]  x;
        logic [POS_BITS-1:0]  y;
        logic [11:0]          w;
        logic [11:0]          h;
        logic                 hit;
        logic [12:0]          hit_r;
        logic [12:0]          hit_b;
        logic                 free_ok;
        logic [SLOT_BITS-1:0] free_idx;
    } t_probe;

endpackage
`default_nettype wire

@@ rtl/atlas_rectangle_allocator.sv @@
`default_nettype none
// Rectangle allocator for a set of texture atlases.
// Command channel: drive i_in and pulse i_start while o_busy is low; the item
// is taken at that edge. Each item gives exactly one result on o_out, marked
// by o_strobe for one cycle; the receiver cannot stall it.
// Config channel: i_cfg_valid / o_cfg_ready carry the 4-bit gap register
// (reset value 4). Write it only while the block is idle.
// A release item's result is registered and appears in the cycle after the item
// is taken. An allocation sends candidate positions down a chain of TABLE_DEPTH
// cells, one cell per cycle; each candidate passes every cell and comes back to
// the control, which registers the next one. An empty table and no open atlas
// still cost one pass, to find the free slot. The number of candidates depends on the stored rectangles.
// Only one item is in work at a time.
// Reset clears all slots, the atlas count and the gap register to 4.
module atlas_rectangle_allocator
    import ara_pkg::*;
#(
    parameter int ATLAS_WIDTH  = 2048,
    parameter int ATLAS_HEIGHT = 2048,
    parameter int MAX_ATLASES  = 8,
    parameter int TABLE_DEPTH  = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire t_in        i_in,
    output logic            o_strobe,
    output t_out            o_out,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [3:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_ATLASES + 1);
    localparam logic [15:0] AW = 16'(ATLAS_WIDTH);
    localparam logic [15:0] AH = 16'(ATLAS_HEIGHT);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state           r_state;
    logic [3:0]       r_gap;
    logic [CNT_W-1:0] r_count;
    logic             r_strobe;
    t_out             r_out;
    t_cmd             r_cmd;
    t_probe           r_probe;

    t_probe chain [TABLE_DEPTH+1];
    t_probe ret;

    logic [15:0]       nx_sum;
    logic              wrap_x;
    logic [15:0]       nx;
    logic [15:0]       ny;
    logic              fail_y;
    logic [ATL_BITS:0] next_atlas;
    logic              more_atlas;

    assign chain[0] = r_probe;
    assign ret      = chain[TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        ara_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (r_cmd),
            .i_probe (chain[g]),
            .o_probe (chain[g+1])
        );
    end

    // next candidate after a collision
    always_comb begin
        nx_sum     = 16'(ret.hit_r) + 16'(r_gap);
        wrap_x     = (nx_sum + 16'(ret.w)) >= AW;
        nx         = wrap_x ? 16'd0 : nx_sum;
        ny         = wrap_x ? (16'(ret.hit_b) + 16'(r_gap)) : 16'(ret.y);
        fail_y     = (ny + 16'(ret.h)) >= AH;
        next_atlas = (ATL_BITS+1)'(ret.atlas) + 1'b1;
        more_atlas = 32'(next_atlas) < 32'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_gap          <= 4'(GAP_RESET);
            r_count        <= '0;
            r_strobe       <= 1'b0;
            r_cmd.wr       <= 1'b0;
            r_cmd.clr      <= 1'b0;
            r_probe.active <= 1'b0;
        end else begin
            r_strobe       <= 1'b0;
            r_cmd.wr       <= 1'b0;
            r_cmd.clr      <= 1'b0;
            r_probe.active <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_gap <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_in.mode == MODE_RELEASE) begin
                            r_cmd.clr <= 32'(i_in.release_slot) < TABLE_DEPTH;
                            r_cmd.slot <= SLOT_BITS'(i_in.release_slot);
                            r_strobe <= 1'b1;
                            r_out <= '{status: STATUS_RELEASE, atlas_index: 3'd0,
                                       place_x: 11'd0, place_y: 11'd0,
                                       slot: i_in.release_slot};
                        end else begin
                            r_probe <= '{active: 1'b1, chk: (r_count != '0),
                                         atlas: '0, x: '0, y: '0,
                                         w: i_in.req_width, h: i_in.req_height,
                                         hit: 1'b0, hit_r: '0, hit_b: '0,
                                         free_ok: 1'b0, free_idx: '0};
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (ret.active) begin
                        if (!ret.free_ok) begin
                            r_strobe <= 1'b1;
                            r_out    <= '{status: STATUS_REFUSE, default: '0};
                            r_state  <= S_IDLE;
                        end else if (ret.chk && !ret.hit) begin
                            r_cmd <= '{wr: 1'b1, clr: 1'b0, slot: ret.free_idx,
                                       atlas: ret.atlas, left: ret.x[10:0],
                                       top: ret.y[10:0], wide: ret.w, tall: ret.h};
                            r_strobe <= 1'b1;
                            r_out <= '{status: STATUS_OPEN, atlas_index: 3'(ret.atlas),
                                       place_x: ret.x[10:0], place_y: ret.y[10:0],
                                       slot: 6'(ret.free_idx)};
                            r_state <= S_IDLE;
                        end else if (ret.chk && !fail_y) begin
                            // retry in this atlas past the collider
                            r_probe       <= ret;
                            r_probe.x     <= POS_BITS'(nx);
                            r_probe.y     <= POS_BITS'(ny);
                            r_probe.hit   <= 1'b0;
                            r_probe.free_ok <= 1'b0;
                        end else if (ret.chk && more_atlas) begin
                            r_probe       <= ret;
                            r_probe.atlas <= ATL_BITS'(next_atlas);
                            r_probe.x     <= '0;
                            r_probe.y     <= '0;
                            r_probe.hit   <= 1'b0;
                            r_probe.free_ok <= 1'b0;
                        end else if (32'(r_count) >= MAX_ATLASES) begin
                            r_strobe <= 1'b1;
                            r_out    <= '{status: STATUS_REFUSE, default: '0};
                            r_state  <= S_IDLE;
                        end else begin
                            // open a new atlas, place at its origin
                            r_count <= r_count + 1'b1;
                            r_cmd <= '{wr: 1'b1, clr: 1'b0, slot: ret.free_idx,
                                       atlas: ATL_BITS'(r_count), left: 11'd0,
                                       top: 11'd0, wide: ret.w, tall: ret.h};
                            r_strobe <= 1'b1;
                            r_out <= '{status: STATUS_NEW, atlas_index: 3'(r_count),
                                       place_x: 11'd0, place_y: 11'd0,
                                       slot: 6'(ret.free_idx)};
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_out       = r_out;

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_ATLASES)
        else $error("atlas count above limit");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_in.mode == MODE_ALLOC) |=> o_busy)
        else $error("allocation did not start a scan");

    a_release_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_in.mode == MODE_RELEASE) |=>
            (o_strobe && o_out.status == STATUS_RELEASE))
        else $error("release result missing");

    a_no_result_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !ret.active)
        else $error("result while a candidate is in the chain");

endmodule
`default_nettype wire

@@ rtl/ara_cell.sv @@
`default_nettype none
module ara_cell
    import ara_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cmd   i_cmd,
    input  wire t_probe i_probe,
    output t_probe      o_probe
);

    logic                r_valid;
    logic [ATL_BITS-1:0] r_atlas;
    logic [10:0]         r_left;
    logic [10:0]         r_top;
    logic [11:0]         r_wide;
    logic [11:0]         r_tall;
    logic                r_active;
    t_probe              r_probe;
    t_probe              n_probe;

    logic [12:0] right_edge;
    logic [12:0] bottom_edge;
    logic        apart;
    logic        overlap;
    logic        sel;

    assign sel = (i_cmd.slot == SLOT_BITS'(IDX));

    assign right_edge  = 13'(r_left) + 13'(r_wide);
    assign bottom_edge = 13'(r_top) + 13'(r_tall);

    always_comb begin
        apart = (15'(i_probe.x) >= 15'(right_edge))
             || (15'(i_probe.x) + 15'(i_probe.w) <= 15'(r_left))
             || (15'(i_probe.y) >= 15'(bottom_edge))
             || (15'(i_probe.y) + 15'(i_probe.h) <= 15'(r_top));
        overlap = r_valid && (r_atlas == i_probe.atlas) && !apart;
        n_probe = i_probe;
        if (i_probe.active) begin
            if (i_probe.chk && !i_probe.hit && overlap) begin
                n_probe.hit   = 1'b1;
                n_probe.hit_r = right_edge;
                n_probe.hit_b = bottom_edge;
            end
            if (!i_probe.free_ok && !r_valid) begin
                n_probe.free_ok  = 1'b1;
                n_probe.free_idx = SLOT_BITS'(IDX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_active <= n_probe.active;
            if (i_cmd.wr && sel) begin
                r_valid <= 1'b1;
            end else if (i_cmd.clr && sel) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
        if (i_cmd.wr && sel) begin
            r_atlas <= i_cmd.atlas;
            r_left  <= i_cmd.left;
            r_top   <= i_cmd.top;
            r_wide  <= i_cmd.wide;
            r_tall  <= i_cmd.tall;
        end
    end

    always_comb begin
        o_probe        = r_probe;
        o_probe.active = r_active;
    end

endmodule
`default_nettype wire

@@ verif/atlas_rectangle_allocator_tb.sv @@
`default_nettype none

class atlas_scoreboard;
    localparam int ATLAS_W = 2048;
    localparam int ATLAS_H = 2048;
    localparam int ATLAS_MAX = 8;
    localparam int DEPTH = 64;

    int unsigned spacing;
    bit          used [DEPTH];
    int unsigned owner [DEPTH];
    int unsigned left_x [DEPTH];
    int unsigned top_y [DEPTH];
    int unsigned wide [DEPTH];
    int unsigned tall [DEPTH];
    int unsigned open_atlases;
    ara_pkg::t_out pending [$];
    int errors;
    int n_open, n_new, n_release, n_refuse;

    function new();
        spacing = ara_pkg::GAP_RESET;
        open_atlases = 0;
        errors = 0;
        n_open = 0; n_new = 0; n_release = 0; n_refuse = 0;
        foreach (used[i]) used[i] = 0;
    endfunction

    function void set_gap(logic [3:0] v);
        spacing = v;
    endfunction

    function void queue_result(ara_pkg::t_out r);
        pending.insert(pending.size(), r);
    endfunction

    function int overlap_slot(int unsigned a, int unsigned x, int unsigned y,
                              int unsigned w, int unsigned h);
        for (int i = 0; i < DEPTH; i++) begin
            if (!used[i] || owner[i] != a) continue;
            if (x >= left_x[i] + wide[i] || x + w <= left_x[i] ||
                y >= top_y[i] + tall[i] || y + h <= top_y[i]) continue;
            return i;
        end
        return -1;
    endfunction

    function bit fit_in_atlas(int unsigned a, int unsigned w, int unsigned h,
                              output int unsigned px, output int unsigned py);
        int unsigned x;
        int unsigned y;
        int k;
        x = 0;
        y = 0;
        forever begin
            k = overlap_slot(a, x, y, w, h);
            if (k < 0) begin
                px = x;
                py = y;
                return 1;
            end
            x = left_x[k] + wide[k] + spacing;
            if (x + w >= ATLAS_W) begin
                x = 0;
                y = top_y[k] + tall[k] + spacing;
            end
            if (y + h >= ATLAS_H) return 0;
        end
    endfunction

    // note an accepted item and queue the result it must produce
    function void note_item(ara_pkg::t_in it);
        ara_pkg::t_out r;
        int free_slot;
        int unsigned a, x, y;
        bit found;
        r = '0;
        r.status = ara_pkg::STATUS_REFUSE;
        free_slot = -1;
        found = 0;
        x = 0;
        y = 0;
        if (it.mode == ara_pkg::MODE_RELEASE) begin
            used[it.release_slot] = 0;
            r.status = ara_pkg::STATUS_RELEASE;
            r.slot = it.release_slot;
            queue_result(r);
            return;
        end
        for (int i = 0; i < DEPTH; i++)
            if (!used[i]) begin
                free_slot = i;
                break;
            end
        if (free_slot < 0) begin
            queue_result(r);
            return;
        end
        for (a = 0; a < open_atlases; a++)
            if (fit_in_atlas(a, it.req_width, it.req_height, x, y)) begin
                found = 1;
                r.status = ara_pkg::STATUS_OPEN;
                break;
            end
        if (!found) begin
            if (open_atlases >= ATLAS_MAX) begin
                queue_result(r);
                return;
            end
            a = open_atlases;
            open_atlases++;
            x = 0;
            y = 0;
            r.status = ara_pkg::STATUS_NEW;
        end
        x &= 11'h7ff;
        y &= 11'h7ff;
        used[free_slot] = 1;
        owner[free_slot] = a;
        left_x[free_slot] = x;
        top_y[free_slot] = y;
        wide[free_slot] = it.req_width;
        tall[free_slot] = it.req_height;
        r.atlas_index = a[2:0];
        r.place_x = x[10:0];
        r.place_y = y[10:0];
        r.slot = free_slot[5:0];
        queue_result(r);
    endfunction

    function void check_result(ara_pkg::t_out got);
        ara_pkg::t_out exp;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        case (exp.status)
            ara_pkg::STATUS_OPEN:    n_open++;
            ara_pkg::STATUS_NEW:     n_new++;
            ara_pkg::STATUS_RELEASE: n_release++;
            default:                 n_refuse++;
        endcase
        if (got.status !== exp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
            errors++;
        end
        if (got.atlas_index !== exp.atlas_index) begin
            $display("%0t: atlas_index expected %0d actual %0d", $time,
                     exp.atlas_index, got.atlas_index);
            errors++;
        end
        if (got.place_x !== exp.place_x) begin
            $display("%0t: place_x expected %0d actual %0d", $time, exp.place_x, got.place_x);
            errors++;
        end
        if (got.place_y !== exp.place_y) begin
            $display("%0t: place_y expected %0d actual %0d", $time, exp.place_y, got.place_y);
            errors++;
        end
        if (got.slot !== exp.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, exp.slot, got.slot);
            errors++;
        end
    endfunction
endclass

module atlas_rectangle_allocator_tb;
    import ara_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    t_in        i_in;
    logic       o_strobe;
    t_out       o_out;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_data;

    atlas_scoreboard placements;
    int          quiet_cycles;
    bit          allow_idle;
    int          items_sent;

    atlas_rectangle_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_in       (i_in),
        .o_strobe   (o_strobe),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            placements.check_result(o_out);
        end
        if (!i_rst_n || (i_start && !o_busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(t_in it);
        @(negedge i_clk);
        i_in = it;
        i_start = 1'b1;
        do @(posedge i_clk); while (o_busy);
        placements.note_item(it);
        items_sent++;
    endtask

    task automatic pause(int n);
        @(negedge i_clk);
        i_start = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // hold off until every placement has come back, then let the block settle
    task automatic drain();
        pause(1);
        while (placements.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_gap(logic [3:0] v);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        placements.set_gap(v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_in alloc_item(int w, int h);
        t_in it;
        it = '0;
        it.mode = MODE_ALLOC;
        it.req_width = w[11:0];
        it.req_height = h[11:0];
        it.release_slot = 6'($urandom_range(0, 63));
        return it;
    endfunction

    function automatic t_in free_item(int s);
        t_in it;
        it.mode = MODE_RELEASE;
        it.req_width = 12'($urandom);
        it.req_height = 12'($urandom);
        it.release_slot = s[5:0];
        return it;
    endfunction

    function automatic int pick_size();
        int p;
        p = int'($urandom_range(0, 99));
        if (p < 60) return int'($urandom_range(1, 200));
        if (p < 75) return int'($urandom_range(201, 1000));
        if (p < 85) return int'($urandom_range(1001, 2048));
        if (p < 95) return int'($urandom_range(0, 4095));
        return (p[0]) ? 0 : 2047;
    endfunction

    task automatic random_phase(int count, int release_pct);
        t_in it;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < release_pct)
                it = free_item(int'($urandom_range(0, 63)));
            else
                it = alloc_item(pick_size(), pick_size());
            send_item(it);
            if (allow_idle && $urandom_range(0, 9) == 0)
                pause(int'($urandom_range(1, 12)));
        end
    endtask

    initial begin
        placements = new();
        items_sent = 0;
        allow_idle = 1'b1;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 4'd0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // free slot release, full-size atlases up to the limit, odd sizes
        send_item(free_item(63));
        send_item(alloc_item(2048, 2048));
        send_item(alloc_item(0, 0));
        send_item(alloc_item(4095, 4095));
        send_item(alloc_item(0, 4095));
        for (int i = 0; i < 7; i++) send_item(alloc_item(2048, 2048));
        send_item(alloc_item(1, 1));
        send_item(free_item(0));
        send_item(free_item(1));
        send_item(alloc_item(100, 50));
        send_item(alloc_item(2047, 1));
        send_item(alloc_item(1, 2047));
        pause(int'($urandom_range(1, 12)));
        for (int s = 0; s < 64; s++) send_item(free_item(s));

        write_gap(4'd0);
        random_phase(450, 30);
        write_gap(4'd15);
        random_phase(450, 20);
        write_gap(4'($urandom_range(1, 14)));
        random_phase(450, 50);
        write_gap(4'd4);
        allow_idle = 1'b0;
        random_phase(450, 35);

        drain();
        repeat (100) @(negedge i_clk);
        $display("Sent %0d items: %0d into open atlases, %0d into new atlases,",
                 items_sent, placements.n_open, placements.n_new);
        $display("%0d releases, %0d refusals; gap swept from 0 to 15",
                 placements.n_release, placements.n_refuse);
        if (placements.errors == 0 && placements.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire
